>>> src/programmable_table_fsm_assert.svh
// ============================================================================
// programmable_table_fsm_assert.svh
// Assertion macros for the table-driven state machine RTL.
// ============================================================================
`ifndef PROGRAMMABLE_TABLE_FSM_ASSERT_SVH
`define PROGRAMMABLE_TABLE_FSM_ASSERT_SVH

// same-cycle implication
`define PTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ptf_pkg.sv
// ============================================================================
// ptf_pkg
// Types and codes for the table-driven state machine.
// ============================================================================
package ptf_pkg;

    localparam logic [1:0] ACT_DEFINE = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;
    localparam logic [1:0] ACT_EVENT  = 2'd3;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_POOL_FULL  = 2'd1;
    localparam logic [1:0] STS_SLOT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] state_id;
        logic [6:0] count;
        logic       has_begin;
        logic       has_run;
        logic       has_end;
        logic [5:0] slot;
        logic [7:0] event_req;
        logic       is_other;
        logic [3:0] target_id;
        logic       target_none;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       begin_fired;
        logic       run_fired;
        logic       end_fired;
        logic       switched;
        logic [3:0] current_state;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic is_event;
    } t_stat;

endpackage

>>> src/programmable_table_fsm.sv
// ============================================================================
// programmable_table_fsm
// Run-time programmable table-driven state machine: states own runs of
// transition slots from a shared pool; event requests scan those slots.
// ============================================================================
//
// channel   ports                      direction  handshake
// request   start, busy, i_req         in         start & !busy
// result    o_valid, o_rsp             out        o_valid, one cycle
// config    i_cfg_we, i_cfg_wdata      in         i_cfg_we
//
// Define, set and start requests: busy through the lookup and done states
// after accept, result strobe in done; no new request until busy drops.
// Event request: busy through lookup, a scan of the slots of the current
// state and done, result strobe in done; a taken or blocked slot ends the
// scan early. The slot memory read port scans one slot per cycle.
// After reset busy stays high while the slot memory is cleared.
// Results cannot be stalled; each result is shown for one cycle only.
//
module programmable_table_fsm import ptf_pkg::*; #(
    parameter int NUM_STATES = 16,
    parameter int POOL_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_req       i_req,
    output logic       busy,
    output logic       o_valid,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    ptf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ptf_dp #(
        .NUM_STATES (NUM_STATES),
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

endmodule

>>> src/ptf_ctrl.sv
// ============================================================================
// ptf_ctrl
// Sequencer: slot memory clear, request lookup, slot scan, result strobe.
// ============================================================================
module ptf_ctrl import ptf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = i_stat.is_event ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd.clear = (r_state == ST_CLEAR);
        o_cmd.load  = (r_state == ST_IDLE) && i_start;
        o_cmd.exec  = (r_state == ST_LOOKUP);
        o_cmd.scan  = (r_state == ST_SCAN);
        o_busy      = (r_state != ST_IDLE);
        o_valid     = (r_state == ST_DONE);
    end

`include "programmable_table_fsm_assert.svh"

    `PTF_ASSERT_NEXT(a_clear_once, r_state != ST_CLEAR, r_state != ST_CLEAR, "clear pass re-entered")
    `PTF_ASSERT_NOW(a_scan_event, r_state == ST_SCAN, i_stat.is_event, "scan on non-event request")
    `PTF_ASSERT_NOW(a_done_src, r_state == ST_DONE, $past(r_state) == ST_LOOKUP || $past(r_state) == ST_SCAN, "result without work")

endmodule

>>> src/ptf_dp.sv
// ============================================================================
// ptf_dp
// State table, transition slot pool, pool allocator and slot scan datapath.
// ============================================================================
module ptf_dp import ptf_pkg::*; #(
    parameter int NUM_STATES = 16,
    parameter int POOL_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output t_rsp       o_rsp
);

    localparam int SW  = $clog2(NUM_STATES);
    localparam int PW  = $clog2(POOL_SLOTS);
    localparam int CW  = $clog2(POOL_SLOTS + 1);
    localparam int LW  = (CW > 7) ? CW : 7;
    localparam int OW  = (CW > 6) ? CW : 6;
    localparam int AW  = ((PW > 6) ? PW : 6) + 1;
    localparam int SAW = CW + 1;

    typedef struct packed {
        logic [PW-1:0] base;
        logic [CW-1:0] cnt;
        logic          f_end;
        logic          f_run;
        logic          f_begin;
    } t_srec;

    typedef struct packed {
        logic [7:0]    ev;
        logic          other;
        logic [SW-1:0] tgt;
        logic          none;
    } t_slot;

    function automatic logic [SW-1:0] f_sid(input logic [3:0] v);
        logic [8:0] t;
        t = {5'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= 9'(NUM_STATES)) t = t - 9'(NUM_STATES);
        end
        return SW'(t);
    endfunction

    t_srec st_mem [NUM_STATES];
    t_slot sl_mem [POOL_SLOTS];

    logic [7:0]            r_mask;
    logic [SW-1:0]         r_current;
    logic                  r_entered;
    logic [CW-1:0]         r_next_free;
    logic [NUM_STATES-1:0] r_init;
    logic [PW-1:0]         r_clr;
    logic [CW-1:0]         r_idx;
    logic                  r_pend;
    logic                  r_earlier;

    t_req          r_req;
    logic [SW-1:0] r_sid;
    logic [SW-1:0] r_tgt;
    t_srec         r_srec;
    logic          r_srec_ok;
    t_slot         r_slot;
    logic [1:0]    r_status;
    logic          r_bf;
    logic          r_rf;
    logic          r_ef;
    logic          r_sw;

    logic [SW-1:0] sid_in;
    logic [SW-1:0] tgt_in;
    logic [SW-1:0] rd_sid;
    logic [CW-1:0] free;
    logic          fits;
    logic          in_range;
    logic [PW-1:0] set_addr;
    logic [PW-1:0] scan_addr;
    logic [CW-1:0] n_eff;
    logic          idx_more;
    logic          mm;
    logic          hit_ok;
    logic          blk;
    logic          take;
    logic          st_we;
    t_srec         st_wdata;
    logic          sl_we;
    logic [PW-1:0] sl_waddr;
    t_slot         sl_wdata;

    always_comb begin
        sid_in    = f_sid(i_req.state_id);
        tgt_in    = f_sid(i_req.target_id);
        rd_sid    = (i_req.action == ACT_EVENT) ? r_current : sid_in;
        free      = CW'(POOL_SLOTS) - r_next_free;
        fits      = LW'(r_req.count) <= LW'(free);
        in_range  = r_srec_ok && (OW'(r_req.slot) < OW'(r_srec.cnt));
        set_addr  = PW'(AW'(r_srec.base) + AW'(r_req.slot));
        scan_addr = PW'(SAW'(r_srec.base) + SAW'(r_idx));
        n_eff     = r_srec_ok ? r_srec.cnt : '0;
        idx_more  = r_idx < n_eff;
        mm        = ((r_slot.ev ^ r_req.event_req) & r_mask) == 8'h00;
        hit_ok    = r_pend && (mm || r_slot.other) && !r_slot.none && r_init[r_slot.tgt];
        blk       = hit_ok && r_slot.other && r_earlier;
        take      = hit_ok && !blk;

        st_we            = i_cmd.exec && (r_req.action == ACT_DEFINE) && fits;
        st_wdata.base    = PW'(r_next_free);
        st_wdata.cnt     = CW'(r_req.count);
        st_wdata.f_end   = r_req.has_end;
        st_wdata.f_run   = r_req.has_run;
        st_wdata.f_begin = r_req.has_begin;

        sl_we          = i_cmd.clear || (i_cmd.exec && (r_req.action == ACT_SET) && in_range);
        sl_waddr       = i_cmd.clear ? r_clr : set_addr;
        sl_wdata.ev    = i_cmd.clear ? 8'h00 : (r_req.is_other ? 8'hFF : r_req.event_req);
        sl_wdata.other = !i_cmd.clear && r_req.is_other;
        sl_wdata.tgt   = i_cmd.clear ? '0 : r_tgt;
        sl_wdata.none  = i_cmd.clear || r_req.target_none;
    end

    always_ff @(posedge i_clk) begin
        if (st_we) st_mem[r_sid] <= st_wdata;
        if (i_cmd.load) begin
            r_srec    <= st_mem[rd_sid];
            r_srec_ok <= r_init[rd_sid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sl_we) sl_mem[sl_waddr] <= sl_wdata;
        r_slot <= sl_mem[scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= 8'hFF;
            r_current   <= '0;
            r_entered   <= 1'b0;
            r_next_free <= '0;
            r_init      <= '0;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_earlier   <= 1'b0;
        end else begin
            if (i_cfg_we) r_mask <= i_cfg_wdata;
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.exec) begin
                case (r_req.action)
                    ACT_DEFINE: begin
                        if (fits) begin
                            r_init[r_sid] <= 1'b1;
                            r_next_free   <= r_next_free + CW'(r_req.count);
                        end
                    end
                    ACT_START: begin
                        r_current <= r_sid;
                        r_entered <= 1'b0;
                    end
                    ACT_EVENT: begin
                        r_entered <= 1'b1;
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_earlier <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.scan) begin
                if (r_pend && mm) r_earlier <= 1'b1;
                if (take) begin
                    r_current <= r_slot.tgt;
                    r_entered <= 1'b0;
                end
                r_pend <= idx_more;
                if (idx_more) r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_sid <= sid_in;
            r_tgt <= tgt_in;
        end
        if (i_cmd.exec) begin
            r_status <= ((r_req.action == ACT_DEFINE) && !fits) ? STS_POOL_FULL :
                        ((r_req.action == ACT_SET) && !in_range) ? STS_SLOT_RANGE : STS_OK;
            r_bf     <= (r_req.action == ACT_EVENT) && !r_entered && r_srec_ok && r_srec.f_begin;
            r_rf     <= (r_req.action == ACT_EVENT) && r_srec_ok && r_srec.f_run;
            r_ef     <= 1'b0;
            r_sw     <= 1'b0;
        end
        if (i_cmd.scan && take) begin
            r_ef <= r_srec_ok && r_srec.f_end;
            r_sw <= 1'b1;
        end
    end

    always_comb begin
        o_stat.clr_last  = (r_clr == PW'(POOL_SLOTS - 1));
        o_stat.scan_done = hit_ok || !idx_more;
        o_stat.is_event  = (r_req.action == ACT_EVENT);

        o_rsp.status        = r_status;
        o_rsp.begin_fired   = r_bf;
        o_rsp.run_fired     = r_rf;
        o_rsp.end_fired     = r_ef;
        o_rsp.switched      = r_sw;
        o_rsp.current_state = 4'(r_current);
    end

endmodule

>>> dv/tb_top.sv
// ============================================================================
// tb_top
// Testbench for the run-time programmable table-driven state machine.
// A directed table covers reset behavior, pool exhaustion, slot range
// errors, undefined states, catch-all slots and state switching. Random
// phases then build and exercise state tables under a range of event
// masks. Each result is checked against its typed directed-table row or
// an in-bench model of the state tables, slot pool and current state.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import ptf_pkg::*;

    localparam int NUM_STATES  = 16;
    localparam int POOL_SLOTS  = 64;
    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 80;
    localparam logic [15:0] CATCH_ALL_EVT = 16'hFFFF;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    t_req       i_req       = '0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       busy;
    logic       o_valid;
    t_rsp       o_rsp;

    // model state
    logic [7:0]  evt_mask;
    logic [5:0]  st_base  [NUM_STATES];
    logic [6:0]  st_count [NUM_STATES];
    logic [3:0]  st_flags [NUM_STATES];
    logic [15:0] slot_evt [POOL_SLOTS];
    logic [3:0]  slot_tgt [POOL_SLOTS];
    bit          slot_none[POOL_SLOTS];
    int          pool_used;
    logic [3:0]  cur_state;
    bit          entered;

    t_rsp     pending_results[$];
    t_dir_row dir_rows[$];
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    bit       no_gaps      = 1'b0;
    logic [7:0] mask_plan[7];

    programmable_table_fsm #(
        .NUM_STATES(NUM_STATES),
        .POOL_SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit evt_hit(input logic [15:0] stored, input logic [7:0] ev);
        return (stored[7:0] & evt_mask) == (ev & evt_mask);
    endfunction

    function automatic t_rsp fsm_step(input t_req r);
        t_rsp       rsp;
        logic [3:0] sid;
        logic [3:0] fl;
        int         n;
        int         base;
        int         idx;
        bit         catch_all;
        bit         earlier;
        rsp = '0;
        sid = r.state_id;
        case (r.action)
            ACT_DEFINE: begin
                if (int'(r.count) > POOL_SLOTS - pool_used) begin
                    rsp.status = STS_POOL_FULL;
                end else begin
                    st_base[sid]  = 6'(pool_used);
                    st_count[sid] = r.count;
                    st_flags[sid] = {1'b1, r.has_end, r.has_run, r.has_begin};
                    pool_used += int'(r.count);
                end
            end
            ACT_SET: begin
                if (r.slot >= st_count[sid]) begin
                    rsp.status = STS_SLOT_RANGE;
                end else begin
                    idx = (int'(st_base[sid]) + int'(r.slot)) % POOL_SLOTS;
                    slot_evt[idx]  = r.is_other ? CATCH_ALL_EVT : {8'h00, r.event_req};
                    slot_tgt[idx]  = r.target_id;
                    slot_none[idx] = r.target_none;
                end
            end
            ACT_START: begin
                cur_state = sid;
                entered   = 1'b0;
            end
            default: begin
                fl   = st_flags[cur_state];
                n    = st_count[cur_state];
                base = st_base[cur_state];
                if (!entered) begin
                    rsp.begin_fired = fl[0];
                    entered = 1'b1;
                end
                rsp.run_fired = fl[1];
                for (int i = 0; i < n; i++) begin
                    idx = (base + i) % POOL_SLOTS;
                    catch_all = (slot_evt[idx] == CATCH_ALL_EVT);
                    if (!(evt_hit(slot_evt[idx], r.event_req) || catch_all) ||
                        slot_none[idx] || !st_flags[slot_tgt[idx]][3])
                        continue;
                    if (catch_all) begin
                        earlier = 1'b0;
                        for (int j = 0; j < i; j++) begin
                            if (evt_hit(slot_evt[(base + j) % POOL_SLOTS], r.event_req))
                                earlier = 1'b1;
                        end
                        if (earlier)
                            break;
                    end
                    rsp.end_fired = fl[2];
                    rsp.switched  = 1'b1;
                    cur_state     = slot_tgt[idx];
                    entered       = 1'b0;
                    break;
                end
            end
        endcase
        rsp.current_state = cur_state;
        return rsp;
    endfunction

    function automatic t_req rq(input logic [1:0] act, input int sid, input int cnt,
                                input logic [2:0] fl, input int slt, input logic [7:0] ev,
                                input bit oth, input int tgt, input bit tn);
        t_req r;
        r.action      = act;
        r.state_id    = 4'(sid);
        r.count       = 7'(cnt);
        r.has_begin   = fl[2];
        r.has_run     = fl[1];
        r.has_end     = fl[0];
        r.slot        = 6'(slt);
        r.event_req   = ev;
        r.is_other    = oth;
        r.target_id   = 4'(tgt);
        r.target_none = tn;
        return r;
    endfunction

    function automatic t_rsp rs(input logic [1:0] sts, input logic [3:0] pulses, input int cur);
        t_rsp r;
        r.status        = sts;
        r.begin_fired   = pulses[3];
        r.run_fired     = pulses[2];
        r.end_fired     = pulses[1];
        r.switched      = pulses[0];
        r.current_state = 4'(cur);
        return r;
    endfunction

    task automatic add_row(input t_req r, input bit typed, input t_rsp exp_rsp);
        dir_rows.push_back('{r, typed, exp_rsp});
    endtask

    // mostly defined states, or states that own slots
    function automatic logic [3:0] pick_state(input bit want_slots);
        logic [3:0] sid;
        sid = 4'($urandom_range(0, NUM_STATES - 1));
        if ($urandom_range(0, 99) < 15)
            return sid;
        for (int k = 0; k < 12; k++) begin
            if (want_slots ? (st_count[sid] != 0) : st_flags[sid][3])
                return sid;
            sid = 4'($urandom_range(0, NUM_STATES - 1));
        end
        return sid;
    endfunction

    function automatic logic [7:0] pick_event();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h55;
            3:       return 8'hAA;
            4:       return 8'h0F;
            5:       return 8'hF0;
            6:       return 8'hFF;
            7:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   pick;
        int   room;
        int   lim;
        r    = t_req'($bits(t_req)'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        room = POOL_SLOTS - pool_used;
        if (pick < 7) begin
            r.action = ACT_DEFINE;
            if ($urandom_range(0, 9) != 0) begin
                lim = (room < 5) ? room : 5;
                r.count = (room > 0) ? 7'($urandom_range(1, lim)) : 7'($urandom_range(1, 127));
            end
        end else if (pick < 45) begin
            r.action   = ACT_SET;
            r.state_id = pick_state(1'b1);
            if (st_count[r.state_id] != 0 && $urandom_range(0, 99) < 85)
                r.slot = 6'($urandom_range(0, int'(st_count[r.state_id]) - 1));
            r.event_req   = pick_event();
            r.is_other    = ($urandom_range(0, 99) < 20);
            r.target_id   = pick_state(1'b0);
            r.target_none = ($urandom_range(0, 99) < 15);
        end else if (pick < 55) begin
            r.action   = ACT_START;
            r.state_id = pick_state(1'b0);
        end else begin
            r.action    = ACT_EVENT;
            r.event_req = pick_event();
        end
        return r;
    endfunction

    function automatic int idle_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_req(input t_req r, input bit typed, input t_rsp typed_rsp);
        int   gap;
        t_rsp exp_rsp;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        exp_rsp = fsm_step(r);
        if (typed)
            exp_rsp = typed_rsp;
        pending_results.push_back(exp_rsp);
    endtask

    // drain all requests before touching the mask
    task automatic write_mask(input logic [7:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        evt_mask = value;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: sts=%0d b=%0d r=%0d e=%0d sw=%0d cur=%0d",
                             o_rsp.status, o_rsp.begin_fired, o_rsp.run_fired,
                             o_rsp.end_fired, o_rsp.switched, o_rsp.current_state);
            end else begin
                exp_rsp = pending_results.pop_front();
                if (o_rsp.status !== exp_rsp.status ||
                    o_rsp.begin_fired !== exp_rsp.begin_fired ||
                    o_rsp.run_fired !== exp_rsp.run_fired ||
                    o_rsp.end_fired !== exp_rsp.end_fired ||
                    o_rsp.switched !== exp_rsp.switched ||
                    o_rsp.current_state !== exp_rsp.current_state) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $write("mismatch: exp sts=%0d b=%0d r=%0d e=%0d sw=%0d cur=%0d",
                               exp_rsp.status, exp_rsp.begin_fired, exp_rsp.run_fired,
                               exp_rsp.end_fired, exp_rsp.switched, exp_rsp.current_state);
                        $display(" got sts=%0d b=%0d r=%0d e=%0d sw=%0d cur=%0d",
                                 o_rsp.status, o_rsp.begin_fired, o_rsp.run_fired,
                                 o_rsp.end_fired, o_rsp.switched, o_rsp.current_state);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        evt_mask  = 8'hFF;
        pool_used = 0;
        cur_state = '0;
        entered   = 1'b0;
        for (int i = 0; i < NUM_STATES; i++) begin
            st_base[i]  = '0;
            st_count[i] = '0;
            st_flags[i] = '0;
        end
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_evt[i]  = '0;
            slot_tgt[i]  = '0;
            slot_none[i] = 1'b1;
        end

        // reset mask is all ones for the whole table
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'hFF, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 3, 0, 3'b000, 0, 8'h55, 0, 1, 0), 1, rs(STS_SLOT_RANGE, 4'b0000, 0));
        add_row(rq(ACT_DEFINE, 0, 127, 3'b111, 0, 0, 0, 0, 0), 1, rs(STS_POOL_FULL, 4'b0000, 0));
        add_row(rq(ACT_DEFINE, 0, 65, 3'b111, 0, 0, 0, 0, 0), 1, rs(STS_POOL_FULL, 4'b0000, 0));
        add_row(rq(ACT_DEFINE, 0, 0, 3'b111, 0, 0, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'h00, 0, 0, 0), 1, rs(STS_OK, 4'b0100, 0));
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'hFF, 0, 0, 0), 1, rs(STS_OK, 4'b0100, 0));
        add_row(rq(ACT_DEFINE, 1, 4, 3'b101, 0, 0, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_DEFINE, 15, 6, 3'b011, 0, 0, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 1, 0, 3'b000, 0, 8'h55, 0, 15, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 1, 0, 3'b000, 1, 8'h00, 1, 0, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 1, 0, 3'b000, 2, 8'hAA, 0, 0, 1), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 1, 0, 3'b000, 4, 8'h12, 0, 0, 0), 1, rs(STS_SLOT_RANGE, 4'b0000, 0));
        add_row(rq(ACT_SET, 15, 0, 3'b000, 63, 8'hFF, 0, 1, 0), 1,
                rs(STS_SLOT_RANGE, 4'b0000, 0));
        add_row(rq(ACT_SET, 15, 0, 3'b000, 0, 8'h00, 0, 3, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_SET, 15, 0, 3'b000, 5, 8'hFF, 0, 1, 0), 1, rs(STS_OK, 4'b0000, 0));
        add_row(rq(ACT_START, 1, 0, 3'b000, 0, 0, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 1));
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'h55, 0, 0, 0), 0, '0);
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'h00, 0, 0, 0), 0, '0);
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'hFF, 0, 0, 0), 0, '0);
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'h12, 0, 0, 0), 0, '0);
        add_row(rq(ACT_START, 1, 0, 3'b000, 0, 0, 0, 0, 0), 1, rs(STS_OK, 4'b0000, 1));
        add_row(rq(ACT_SET, 1, 0, 3'b000, 0, 8'h55, 0, 15, 1), 1, rs(STS_OK, 4'b0000, 1));
        add_row(rq(ACT_EVENT, 0, 0, 3'b000, 0, 8'h55, 0, 0, 0), 0, '0);
        add_row(rq(ACT_START, 15, 127, 3'b111, 63, 8'hFF, 1, 15, 1), 1,
                rs(STS_OK, 4'b0000, 15));

        mask_plan[0] = 8'h0F;
        mask_plan[1] = 8'h00;
        mask_plan[2] = 8'($urandom_range(0, 255));
        mask_plan[3] = 8'hF0;
        mask_plan[4] = 8'h01;
        mask_plan[5] = 8'h80;
        mask_plan[6] = 8'hFF;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        for (int p = 0; p < 7; p++) begin
            write_mask(mask_plan[p]);
            for (int k = 0; k < 250; k++) begin
                if (k % 50 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_req(rand_req(), 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ptf_pkg.sv
src/ptf_ctrl.sv
src/ptf_dp.sv
src/programmable_table_fsm.sv
dv/tb_top.sv
